### hdl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    // Transfer field widths
    localparam int KIND_W     = 1;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int IN_ROW_W   = 5;
    localparam int IN_COL_W   = 7;

    localparam logic [KIND_W-1:0] KIND_PUT  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_READ = 1'b1;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE    = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE      = 8'h20;
    localparam logic [CELL_W-1:0] RESET_CELL      = 16'h0F20;
    localparam logic [ATTR_W-1:0] TEXT_ATTR_RESET = 8'h02;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FILL
    } t_state;

endpackage

`default_nettype wire

### hdl/tcw_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input item channel
interface tcw_in_if;
    import tcw_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [CHAR_W-1:0]   char_code;
    logic [IN_ROW_W-1:0] cell_row;
    logic [IN_COL_W-1:0] cell_col;

    modport source (output valid, kind, char_code, cell_row, cell_col, input ready);
    modport sink   (input valid, kind, char_code, cell_row, cell_col, output ready);
endinterface

// Result item channel
interface tcw_out_if;
    import tcw_pkg::*;
    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   cell_char;
    logic [ATTR_W-1:0]   cell_attr;
    logic [IN_ROW_W-1:0] cursor_row_out;
    logic [IN_COL_W-1:0] cursor_col_out;

    modport source (output valid, cell_char, cell_attr, cursor_row_out, cursor_col_out,
                    input ready);
    modport sink   (input valid, cell_char, cell_attr, cursor_row_out, cursor_col_out,
                    output ready);
endinterface

// Attribute register write channel
interface tcw_cfg_if;
    import tcw_pkg::*;
    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] text_attr;

    modport source (output valid, text_attr, input ready);
    modport sink   (input valid, text_attr, output ready);
endinterface

`default_nettype wire

### hdl/tcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/text_console_writer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Text console writer. Holds a ROWS x COLUMNS screen of 16-bit cells (char in
// the low byte, attribute in the high byte) in one single-port-write,
// registered-read RAM, plus a cursor. Put transfers (kind 0) write the byte
// at the cursor with the current text_attr and advance it; byte 0x0A is a
// newline. Read transfers (kind 1) return one cell and the cursor position;
// a cell outside the screen reads as zero. Rows are kept as a ring with a
// top-row pointer, so a scroll only rewrites the row that becomes the bottom
// one. After reset a clearing pass writes every cell to 0x0F20, one cell
// per cycle, while input stays not ready; attribute writes are taken at
// any time. A put that moves past the last row then has the single RAM
// write port fill the new bottom row, with input not ready meanwhile. A read
// registers the RAM data, then loads it into the output register, waiting
// only while the previous result is still held in the output register.

module text_console_writer_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcw_in_if.sink    i_in,
    tcw_cfg_if.sink   i_cfg,
    tcw_out_if.source o_out
);

    import tcw_pkg::*;

    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

    // Ring row -> RAM row
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    // Control state
    t_state            r_state,     n_state;
    logic [ADDR_W-1:0] r_clr_addr,  n_clr_addr;
    logic [ROW_W-1:0]  r_cur_row,   n_cur_row;
    logic [COL_W-1:0]  r_cur_col,   n_cur_col;
    logic [ROW_W-1:0]  r_top,       n_top;
    logic [COL_W-1:0]  r_fill_cnt,  n_fill_cnt;
    logic [ATTR_W-1:0] r_attr;
    logic              r_out_valid, n_out_valid;

    // Payload
    logic [ADDR_W-1:0] r_fill_addr, n_fill_addr;
    logic [ATTR_W-1:0] r_fill_attr, n_fill_attr;
    logic              r_oob,       n_oob;
    logic [CELL_W-1:0] r_out_cell;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;

    // RAM port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic              in_ready;
    logic              in_xfer;
    logic              ld_out;
    logic              do_nl;
    logic              rd_in_range;
    logic [31:0]       req_row32;
    logic [31:0]       req_col32;
    logic [31:0]       out_row32;
    logic [31:0]       out_col32;
    logic [ADDR_W-1:0] cur_addr;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_xfer    = i_in.valid && in_ready;
    assign i_in.ready = in_ready;
    assign i_cfg.ready = 1'b1;

    // Requested cell, resized to screen widths after the range check
    assign req_row32   = 32'(i_in.cell_row);
    assign req_col32   = 32'(i_in.cell_col);
    assign rd_in_range = (req_row32 < 32'(ROWS)) && (req_col32 < 32'(COLUMNS));
    assign ram_raddr   = cell_addr(phys_row(req_row32[ROW_W-1:0], r_top),
                                   req_col32[COL_W-1:0]);
    assign cur_addr    = cell_addr(phys_row(r_cur_row, r_top), r_cur_col);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_top       = r_top;
        n_fill_cnt  = r_fill_cnt;
        n_fill_addr = r_fill_addr;
        n_fill_attr = r_fill_attr;
        n_oob       = r_oob;
        ram_we      = 1'b0;
        ram_waddr   = cur_addr;
        ram_wdata   = {r_attr, i_in.char_code};
        ram_re      = 1'b0;
        in_ready    = 1'b0;
        ld_out      = 1'b0;
        do_nl       = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = RESET_CELL;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_xfer) begin
                    if (i_in.kind == KIND_READ) begin
                        ram_re  = 1'b1;
                        n_oob   = !rd_in_range;
                        n_state = ST_READ;
                    end else if (i_in.char_code == NEWLINE_CODE) begin
                        do_nl = 1'b1;
                    end else begin
                        ram_we = 1'b1;
                        if (r_cur_col == LAST_COL) begin
                            do_nl = 1'b1;
                        end else begin
                            n_cur_col = r_cur_col + 1'b1;
                        end
                    end
                end
            end
            ST_READ: begin
                // rdata holds until the result register frees up
                if (!r_out_valid || o_out.ready) begin
                    ld_out  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_FILL: begin
                ram_we      = 1'b1;
                ram_waddr   = r_fill_addr;
                ram_wdata   = {r_fill_attr, SPACE_CODE};
                n_fill_addr = r_fill_addr + 1'b1;
                n_fill_cnt  = r_fill_cnt + 1'b1;
                if (r_fill_cnt == LAST_COL) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Newline: past the bottom, old top row becomes the blank bottom row
        if (do_nl) begin
            n_cur_col = '0;
            if (r_cur_row == LAST_ROW) begin
                n_top       = (r_top == LAST_ROW) ? '0 : r_top + 1'b1;
                n_fill_addr = cell_addr(r_top, '0);
                n_fill_cnt  = '0;
                n_fill_attr = r_attr;
                n_state     = ST_FILL;
            end else begin
                n_cur_row = r_cur_row + 1'b1;
            end
        end

        n_out_valid = ld_out || (r_out_valid && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_top       <= '0;
            r_fill_cnt  <= '0;
            r_attr      <= TEXT_ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_top       <= n_top;
            r_fill_cnt  <= n_fill_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_attr <= i_cfg.text_attr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_addr <= n_fill_addr;
        r_fill_attr <= n_fill_attr;
        r_oob       <= n_oob;
        if (ld_out) begin
            r_out_cell <= r_oob ? '0 : ram_rdata;
            r_out_row  <= r_cur_row;
            r_out_col  <= r_cur_col;
        end
    end

    // Cursor fields are masked to the transfer widths
    assign out_row32 = 32'(r_out_row);
    assign out_col32 = 32'(r_out_col);

    assign o_out.valid          = r_out_valid;
    assign o_out.cell_char      = r_out_cell[CHAR_W-1:0];
    assign o_out.cell_attr      = r_out_cell[CELL_W-1:CHAR_W];
    assign o_out.cursor_row_out = out_row32[IN_ROW_W-1:0];
    assign o_out.cursor_col_out = out_col32[IN_COL_W-1:0];

    // Cursor and ring pointer stay on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur_row) < 32'(ROWS)) && (32'(r_cur_col) < 32'(COLUMNS)))
        else $error("cursor off screen");

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_top) < 32'(ROWS))
        else $error("top row pointer out of range");

    // An accepted read issues the RAM read and waits for its data
    a_read_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.kind == KIND_READ) |=> (r_state == ST_READ))
        else $error("read transfer did not reach read state");

    // A row fill runs without interruption until the last column
    a_fill_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL && r_fill_cnt != LAST_COL) |=>
            (r_state == ST_FILL && r_fill_cnt == $past(r_fill_cnt) + 1'b1))
        else $error("scroll fill broken");

endmodule

`default_nettype wire

### bench/tb_text_console_writer_top.sv
`timescale 1ns / 1ps

module tb_text_console_writer_top;
    import tcw_pkg::*;

    // Receiver hold-off that fills the block and stalls its input
    localparam int HOLD_CYCLES  = 400;
    // Quiet time before an attribute write: a scrolling put keeps filling the new bottom row
    // after it is taken and produces no result, so an empty expectation queue is not enough
    localparam int QUIET_CYCLES = 2 * COLUMNS + 20;
    localparam int BURST_READS  = 12;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CHAR_W-1:0]   char_code;
        logic [IN_ROW_W-1:0] cell_row;
        logic [IN_COL_W-1:0] cell_col;
    } t_console_item;

    typedef struct packed {
        logic [CHAR_W-1:0]   cell_char;
        logic [ATTR_W-1:0]   cell_attr;
        logic [IN_ROW_W-1:0] cursor_row_out;
        logic [IN_COL_W-1:0] cursor_col_out;
    } t_cell_read;

    // Screen/cursor predictor plus the queue of cell reads still owed by the block
    class console_scoreboard;
        logic [CELL_W-1:0] screen [CELL_COUNT];
        int                cur_row;
        int                cur_col;
        logic [ATTR_W-1:0] attr;
        t_cell_read        pending_reads [$];
        int                mismatches;
        int                reads_checked;
        int                scrolls;
        int                wraps;

        function new();
            foreach (screen[i]) screen[i] = RESET_CELL;
            cur_row       = 0;
            cur_col       = 0;
            attr          = TEXT_ATTR_RESET;
            mismatches    = 0;
            reads_checked = 0;
            scrolls       = 0;
            wraps         = 0;
        endfunction

        function void line_feed();
            cur_col = 0;
            cur_row++;
            if (cur_row >= ROWS) begin
                for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
                for (int c = 0; c < COLUMNS; c++)
                    screen[CELL_COUNT - COLUMNS + c] = {attr, SPACE_CODE};
                cur_row = ROWS - 1;
                scrolls++;
            end
        endfunction

        function void note_transfer(t_console_item it);
            t_cell_read want;
            int         idx;
            if (it.kind == KIND_PUT) begin
                if (it.char_code == NEWLINE_CODE) begin
                    line_feed();
                end else begin
                    idx = cur_row * COLUMNS + cur_col;
                    if (idx < CELL_COUNT) screen[idx] = {attr, it.char_code};
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        wraps++;
                        line_feed();
                    end
                end
            end else begin
                if (it.cell_row < ROWS && it.cell_col < COLUMNS)
                    {want.cell_attr, want.cell_char} = screen[it.cell_row * COLUMNS + it.cell_col];
                else
                    {want.cell_attr, want.cell_char} = '0;
                want.cursor_row_out = IN_ROW_W'(cur_row);
                want.cursor_col_out = IN_COL_W'(cur_col);
                pending_reads.push_back(want);
            end
        endfunction

        function void check_result(t_cell_read got);
            t_cell_read want;
            if (pending_reads.size() == 0) begin
                $error("cell read result with none outstanding: char %0h attr %0h",
                       got.cell_char, got.cell_attr);
                mismatches++;
                return;
            end
            want = pending_reads.pop_front();
            reads_checked++;
            if (got.cell_char !== want.cell_char) begin
                $error("cell_char: expected %0h, actual %0h", want.cell_char, got.cell_char);
                mismatches++;
            end
            if (got.cell_attr !== want.cell_attr) begin
                $error("cell_attr: expected %0h, actual %0h", want.cell_attr, got.cell_attr);
                mismatches++;
            end
            if (got.cursor_row_out !== want.cursor_row_out) begin
                $error("cursor_row_out: expected %0d, actual %0d",
                       want.cursor_row_out, got.cursor_row_out);
                mismatches++;
            end
            if (got.cursor_col_out !== want.cursor_col_out) begin
                $error("cursor_col_out: expected %0d, actual %0d",
                       want.cursor_col_out, got.cursor_col_out);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcw_in_if  in_ch ();
    tcw_cfg_if cfg_ch ();
    tcw_out_if out_ch ();

    text_console_writer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    console_scoreboard sb;

    // Knobs shared between the stimulus and the receiver process
    bit tx_idle_on  = 1'b0;
    bit rx_idle_on  = 1'b0;
    bit hold_output = 1'b0;
    int items_sent  = 0;
    int attr_writes = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: far beyond the slowest legal run (clearing pass, one scroll per put,
    // worst gaps and stalls on every transfer, the long hold-off)
    initial begin
        #800000;
        $display("Regression FAIL");
        $finish;
    end

    // Monitor. Samples at the edge before any of this step's updates land, so
    // attribute writes, input transfers and results are seen in handshake order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) sb.attr = cfg_ch.text_attr;
            if (in_ch.valid && in_ch.ready)
                sb.note_transfer(t_console_item'({in_ch.kind, in_ch.char_code,
                                                  in_ch.cell_row, in_ch.cell_col}));
            if (out_ch.valid && out_ch.ready)
                sb.check_result(t_cell_read'({out_ch.cell_char, out_ch.cell_attr,
                                              out_ch.cursor_row_out, out_ch.cursor_col_out}));
        end
    end

    // Receiver. Ready is held high, with random stall bursts when enabled,
    // and a long hold-off on request so reads back up into the input channel.
    initial begin
        forever begin
            if (hold_output) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one item and hold it until the transfer; returns on the accepting edge
    // with valid still high, so a following item goes out back to back.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] code,
                             input logic [IN_ROW_W-1:0] row, input logic [IN_COL_W-1:0] col);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.char_code <= code;
        in_ch.cell_row  <= row;
        in_ch.cell_col  <= col;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Row/column of a put are don't-care, so they carry random bits
    task automatic put_char(input logic [CHAR_W-1:0] code);
        send_item(KIND_PUT, code, IN_ROW_W'($urandom_range(0, 31)),
                  IN_COL_W'($urandom_range(0, 127)));
    endtask

    // Half of the reads go to the leading columns of the cursor row or the row above it,
    // some anywhere on screen, some across the full field ranges, on or off the screen
    task automatic read_cell();
        int sel;
        int row;
        int col;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            row = sb.cur_row;
            if (row > 0 && $urandom_range(0, 1)) row--;
            col = $urandom_range(0, 7);
        end else if (sel < 8) begin
            row = $urandom_range(0, ROWS - 1);
            col = $urandom_range(0, COLUMNS - 1);
        end else begin
            row = $urandom_range(0, 31);
            col = $urandom_range(0, 127);
        end
        send_item(KIND_READ, CHAR_W'($urandom_range(0, 255)), IN_ROW_W'(row), IN_COL_W'(col));
    endtask

    // Drop valid, wait for every owed read, then let any scroll finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending_reads.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.text_attr <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        attr_writes++;
    endtask

    // Text stream up to a running item count. An optional long line first gets
    // near or past the right edge; after that, short lines keep newlines frequent so the
    // cursor reaches the bottom row and scrolls many times.
    task automatic run_text(input int upto, input bit long_line, input bit may_idle);
        int                n;
        logic [CHAR_W-1:0] code;
        if (long_line) begin
            n = $urandom_range(COLUMNS - 2, COLUMNS + 4);
            repeat (n) begin
                code = CHAR_W'($urandom_range(0, 255));
                if (code == NEWLINE_CODE) code = 8'h0B;
                put_char(code);
            end
            read_cell();
            read_cell();
        end
        while (items_sent < upto) begin
            if (may_idle) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            repeat ($urandom_range(0, 3)) put_char(CHAR_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) != 0) put_char(NEWLINE_CODE);
            if ($urandom_range(0, 1)) read_cell();
        end
    endtask

    initial begin
        sb = new();
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= KIND_PUT;
        in_ch.char_code  <= '0;
        in_ch.cell_row   <= '0;
        in_ch.cell_col   <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.text_attr <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset attribute: cleared screen at both corners, reads off
        // the screen on each axis, extreme bytes, newline
        send_item(KIND_READ, 8'h00, 5'd0, 7'd0);
        send_item(KIND_READ, 8'hFF, IN_ROW_W'(ROWS - 1), IN_COL_W'(COLUMNS - 1));
        send_item(KIND_READ, 8'h00, 5'd31, 7'd127);
        send_item(KIND_READ, 8'h00, IN_ROW_W'(ROWS), 7'd0);
        send_item(KIND_READ, 8'h00, 5'd0, IN_COL_W'(COLUMNS));
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(NEWLINE_CODE);
        put_char(8'h7F);
        send_item(KIND_READ, 8'h00, 5'd0, 7'd0);
        send_item(KIND_READ, 8'h00, 5'd0, 7'd1);
        send_item(KIND_READ, 8'h00, 5'd1, 7'd0);
        put_char(NEWLINE_CODE);
        put_char(NEWLINE_CODE);
        send_item(KIND_READ, 8'h00, 5'd2, 7'd0);
        settle();

        // Attribute extremes; each phase opens with a long line that may wrap
        write_attr(8'h00);
        run_text(110, 1'b1, 1'b1);
        settle();
        write_attr(8'hFF);
        run_text(200, 1'b1, 1'b1);
        settle();

        // Receiver holds off while reads keep coming back to back
        write_attr(ATTR_W'($urandom_range(0, 255)));
        tx_idle_on  = 1'b0;
        hold_output = 1'b1;
        repeat (BURST_READS) read_cell();
        run_text(250, 1'b0, 1'b1);
        settle();

        // Tail without idling on either side
        write_attr(ATTR_W'($urandom_range(0, 255)));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_text(290, 1'b0, 1'b0);
        settle();

        if (sb.pending_reads.size() != 0) begin
            $error("%0d cell reads never returned", sb.pending_reads.size());
            sb.mismatches++;
        end
        $display("Covered %0d input transfers and %0d checked cell reads",
                 items_sent, sb.reads_checked);
        $display("under %0d attribute settings; cursor wrapped %0d times, scrolled %0d times",
                 attr_writes + 1, sb.wraps, sb.scrolls);
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
